// ===== rtl/led_bar_serial_frame_driver_assert.svh =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef LED_BAR_SERIAL_FRAME_DRIVER_ASSERT_SVH
`define LED_BAR_SERIAL_FRAME_DRIVER_ASSERT_SVH

// Check that the consequent holds whenever the antecedent holds.
`define LBSFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never holds.
`define LBSFD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/lbsfd_pkg.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - package
// Word types, request and status codes, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package lbsfd_pkg;

  // Request kinds
  localparam logic [1:0] REQ_SET_ONE = 2'd0;
  localparam logic [1:0] REQ_SET_ALL = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_BAD_LEVEL = 2'd2;
  localparam logic [1:0] STAT_BUSY      = 2'd3;

  // Legal brightness levels
  localparam logic [7:0] LVL_OFF  = 8'h00;
  localparam logic [7:0] LVL_MED  = 8'h0f;
  localparam logic [7:0] LVL_FULL = 8'hff;

  // Configuration register indexes
  localparam logic [1:0] REG_CONTROL_WORD = 2'd0;
  localparam logic [1:0] REG_GAP_TICKS    = 2'd1;
  localparam logic [1:0] REG_BIT_TICKS    = 2'd2;
  localparam logic [1:0] REG_PULSE_TICKS  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] CONTROL_WORD_RST = 16'd0;
  localparam logic [15:0] GAP_TICKS_RST    = 16'd250;
  localparam logic [7:0]  BIT_TICKS_RST    = 8'd10;
  localparam logic [7:0]  PULSE_TICKS_RST  = 8'd1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] led_index;
    logic [7:0] level;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_level;
    logic       data_line;
    logic       clock_line;
    logic       sending;
    logic       frame_done;
  } rsp_t;

  // Classified request as it waits in the queue
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] led_index;
    logic [7:0] level;
    logic [1:0] status;
  } cmd_t;

  // Configuration write bundle
  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  function automatic logic level_ok(input logic [7:0] lvl);
    return (lvl == LVL_OFF) || (lvl == LVL_MED) || (lvl == LVL_FULL);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lbsfd_front.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - front end
// Accepts request words and checks index and level before queueing them.
// ---------------------------------------------------------------------------
`default_nettype none

module lbsfd_front import lbsfd_pkg::*; #(
  parameter int NUM_LEDS = 10
) (
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_data,
  output logic      push_valid,
  output cmd_t      push_cmd,
  input  wire logic queue_full
);

  logic index_ok;
  logic lvl_ok;

  assign index_ok = in_data.led_index < 4'(NUM_LEDS);
  assign lvl_ok   = level_ok(in_data.level);

  // Hold off the source while the queue has no room
  assign in_stall   = queue_full;
  assign push_valid = in_valid;

  // Classify: bad index first, then bad level; busy is left to the back end
  always_comb begin
    push_cmd.kind      = in_data.req_type;
    push_cmd.led_index = in_data.led_index;
    push_cmd.level     = in_data.level;
    push_cmd.status    = STAT_OK;
    case (in_data.req_type)
      REQ_SET_ONE: begin
        if (!index_ok) begin
          push_cmd.status = STAT_BAD_INDEX;
        end else if (!lvl_ok) begin
          push_cmd.status = STAT_BAD_LEVEL;
        end
      end
      REQ_SET_ALL: begin
        if (!lvl_ok) begin
          push_cmd.status = STAT_BAD_LEVEL;
        end
      end
      REQ_READ: begin
        if (!index_ok) begin
          push_cmd.status = STAT_BAD_INDEX;
        end
      end
      default: begin
        push_cmd.status = STAT_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lbsfd_queue.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - command queue
// Two-entry queue that lets the front and back ends stall on their own.
// ---------------------------------------------------------------------------
`default_nettype none

module lbsfd_queue import lbsfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      pop_valid,
  output cmd_t      pop_cmd,
  input  wire logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbsfd_back.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - back end
// Holds levels and configuration, advances the frame serializer one tick per
// tick request and registers the result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "led_bar_serial_frame_driver_assert.svh"

module lbsfd_back import lbsfd_pkg::*; #(
  parameter int NUM_LEDS     = 10,
  parameter int LATCH_PULSES = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  input  wire logic    cmd_valid,
  input  wire cmd_t    cmd,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output rsp_t         out_data
);

  localparam int         PW         = $clog2(LATCH_PULSES + 1);
  localparam logic [7:0] FRAME_BITS = 8'(16 * (NUM_LEDS + 3));

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_GAP  = 7'b0000010,
    PH_BIT  = 7'b0000100,
    PH_LGAP = 7'b0001000,
    PH_HIGH = 7'b0010000,
    PH_LOW  = 7'b0100000,
    PH_EGAP = 7'b1000000
  } phase_t;

  // Configuration
  logic [15:0] control_word;
  logic [15:0] gap_ticks;
  logic [7:0]  bit_ticks;
  logic [7:0]  pulse_ticks;

  // State
  logic [7:0]    led_levels [NUM_LEDS];
  phase_t        phase, phase_next;
  logic [7:0]    bit_position, bit_position_next;
  logic [15:0]   wait_count, wait_count_next;
  logic [PW-1:0] pulse_count, pulse_count_next;
  logic          data_reg, data_reg_next;
  logic          clock_reg, clock_reg_next;

  // Working signals
  logic [15:0]   gap_load;
  logic [15:0]   bit_load;
  logic [15:0]   pulse_load;
  logic [7:0]    pos_inc;
  logic [3:0]    word_idx;
  logic [3:0]    rd_addr;
  logic [7:0]    rd_data;
  logic [15:0]   frame_word;
  logic [PW-1:0] pulse_inc;
  logic          busy;
  logic          done;
  logic [1:0]    status;
  logic [7:0]    read_level;
  logic          led_wr_en;

  assign pop  = cmd_valid && (!out_valid || !out_stall);
  assign busy = phase != PH_IDLE;

  // Zero tick counts act as one
  assign gap_load   = (gap_ticks == '0) ? 16'd1 : gap_ticks;
  assign bit_load   = {8'd0, (bit_ticks == '0) ? 8'd1 : bit_ticks};
  assign pulse_load = {8'd0, (pulse_ticks == '0) ? 8'd1 : pulse_ticks};

  // Level read port: either a read request or the next frame word
  assign pos_inc   = bit_position + 8'd1;
  assign word_idx  = pos_inc[7:4];
  assign rd_addr   = (cmd.kind == REQ_READ) ? cmd.led_index : word_idx - 4'd1;
  assign pulse_inc = pulse_count + 1'b1;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (rd_addr == 4'(i)) begin
        rd_data = led_levels[i];
      end
    end
  end

  always_comb begin
    if (word_idx == 4'd0) begin
      frame_word = control_word;
    end else if (word_idx <= 4'(NUM_LEDS)) begin
      frame_word = {8'd0, rd_data};
    end else begin
      frame_word = '0;
    end
  end

  // Execute one command
  always_comb begin
    phase_next        = phase;
    bit_position_next = bit_position;
    wait_count_next   = wait_count;
    pulse_count_next  = pulse_count;
    data_reg_next     = data_reg;
    clock_reg_next    = clock_reg;
    done              = 1'b0;
    status            = cmd.status;
    read_level        = '0;
    led_wr_en         = 1'b0;
    case (cmd.kind)
      REQ_SET_ONE, REQ_SET_ALL: begin
        if (cmd.status == STAT_OK) begin
          if (busy) begin
            status = STAT_BUSY;
          end else begin
            led_wr_en       = 1'b1;
            phase_next      = PH_GAP;
            wait_count_next = gap_load;
          end
        end
      end
      REQ_READ: begin
        if (cmd.status == STAT_OK) begin
          read_level = rd_data;
        end
      end
      default: begin
        // Tick: count down the wait, then step the sequence
        if (busy) begin
          if (wait_count > 16'd1) begin
            wait_count_next = wait_count - 16'd1;
          end else begin
            case (phase)
              PH_GAP: begin
                bit_position_next = '0;
                data_reg_next     = control_word[15];
                phase_next        = PH_BIT;
                wait_count_next   = bit_load;
              end
              PH_BIT: begin
                clock_reg_next    = ~clock_reg;
                bit_position_next = pos_inc;
                if (pos_inc < FRAME_BITS) begin
                  data_reg_next   = frame_word[~pos_inc[3:0]];
                  wait_count_next = bit_load;
                end else begin
                  data_reg_next   = 1'b0;
                  phase_next      = PH_LGAP;
                  wait_count_next = gap_load;
                end
              end
              PH_LGAP: begin
                pulse_count_next = '0;
                data_reg_next    = 1'b1;
                phase_next       = PH_HIGH;
                wait_count_next  = pulse_load;
              end
              PH_HIGH: begin
                data_reg_next   = 1'b0;
                phase_next      = PH_LOW;
                wait_count_next = pulse_load;
              end
              PH_LOW: begin
                pulse_count_next = pulse_inc;
                if (pulse_inc < PW'(LATCH_PULSES)) begin
                  data_reg_next   = 1'b1;
                  phase_next      = PH_HIGH;
                  wait_count_next = pulse_load;
                end else begin
                  phase_next      = PH_EGAP;
                  wait_count_next = gap_load;
                end
              end
              default: begin
                clock_reg_next  = 1'b0;
                phase_next      = PH_IDLE;
                wait_count_next = '0;
                done            = 1'b1;
              end
            endcase
          end
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= CONTROL_WORD_RST;
      gap_ticks    <= GAP_TICKS_RST;
      bit_ticks    <= BIT_TICKS_RST;
      pulse_ticks  <= PULSE_TICKS_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_CONTROL_WORD: control_word <= cfg.data;
        REG_GAP_TICKS:    gap_ticks    <= cfg.data;
        REG_BIT_TICKS:    bit_ticks    <= cfg.data[7:0];
        REG_PULSE_TICKS:  pulse_ticks  <= cfg.data[7:0];
        default: begin
          control_word <= control_word;
        end
      endcase
    end
  end

  // Level store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_levels[i] <= '0;
      end
    end else if (pop && led_wr_en) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (cmd.kind == REQ_SET_ALL || cmd.led_index == 4'(i)) begin
          led_levels[i] <= cmd.level;
        end
      end
    end
  end

  // Serializer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_position <= '0;
      wait_count   <= '0;
      pulse_count  <= '0;
      data_reg     <= 1'b0;
      clock_reg    <= 1'b0;
    end else if (pop) begin
      phase        <= phase_next;
      bit_position <= bit_position_next;
      wait_count   <= wait_count_next;
      pulse_count  <= pulse_count_next;
      data_reg     <= data_reg_next;
      clock_reg    <= clock_reg_next;
    end
  end

  // Result register: load on pop, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.status     <= status;
      out_data.read_level <= read_level;
      out_data.data_line  <= data_reg_next;
      out_data.clock_line <= clock_reg_next;
      out_data.sending    <= phase_next != PH_IDLE;
      out_data.frame_done <= done;
    end
  end

  `LBSFD_ASSERT_IMPL(a_done_ends_frame, out_valid && out_data.frame_done,
                     !out_data.sending, "frame end reported while still sending")
  `LBSFD_ASSERT_IMPL(a_idle_pins_low, phase == PH_IDLE, !clock_reg && !data_reg,
                     "serial pins not low while idle")
  `LBSFD_ASSERT_NEVER(a_no_overwrite, pop && out_valid && out_stall,
                      "result word overwritten while stalled")
  `LBSFD_ASSERT_IMPL(a_bit_in_frame, phase == PH_BIT, bit_position < FRAME_BITS,
                     "bit position beyond frame length")

endmodule

`default_nettype wire

// ===== rtl/led_bar_serial_frame_driver.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - top level
// Request front end, command queue and serializer back end.
// ---------------------------------------------------------------------------
// Takes one request word per clock while the queue has room and returns
// one result word for each, in order. A request passes the front-end check
// in the cycle it is accepted, waits in a two-entry queue and is executed
// by the back end, which registers its result word; the back end executes
// one command per clock while the result side is not stalled, which sets
// the sustained rate of one word per cycle. The serial pins only move on
// tick requests, one step of the frame sequence per tick. Configuration
// writes take effect at once and belong in idle periods.
`default_nettype none

module led_bar_serial_frame_driver import lbsfd_pkg::*; #(
  parameter int NUM_LEDS     = 10,
  parameter int LATCH_PULSES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output rsp_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic    push_valid;
  cmd_t    push_cmd;
  logic    queue_full;
  logic    cmd_valid;
  cmd_t    cmd;
  logic    pop;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  lbsfd_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  lbsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop_valid  (cmd_valid),
    .pop_cmd    (cmd),
    .pop        (pop)
  );

  lbsfd_back #(
    .NUM_LEDS     (NUM_LEDS),
    .LATCH_PULSES (LATCH_PULSES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/lbsfd_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - testbench scoreboard
// Tracks the LED levels, the register settings and the serializer sequence,
// predicts the result word of every accepted request word and checks the
// result words that the block returns, in order.
// ---------------------------------------------------------------------------
`default_nettype none

package lbsfd_tb_pkg;

  import lbsfd_pkg::*;

  localparam int LED_COUNT   = 10;
  localparam int LATCH_COUNT = 4;
  localparam int FRAME_LEN   = 16 * (LED_COUNT + 3);

  typedef enum logic [2:0] {
    SER_IDLE,
    SER_LEAD_GAP,
    SER_BITS,
    SER_LATCH_GAP,
    SER_PULSE_HIGH,
    SER_PULSE_LOW,
    SER_TAIL_GAP
  } serial_phase_e;

  class led_frame_scoreboard;

    // Register copies
    logic [15:0]   cmd_word;
    logic [15:0]   gap_len;
    logic [7:0]    bit_len;
    logic [7:0]    pulse_len;

    // Serializer and LED state
    logic [7:0]    led_level [LED_COUNT];
    serial_phase_e phase;
    logic [7:0]    bit_pos;
    logic [15:0]   ticks_left;
    logic [2:0]    pulses_done;
    logic          data_pin;
    logic          clock_pin;

    rsp_t          expected_words [$];

    int            errors;
    int            words_seen;
    int            frames_sent;
    int            sets_taken;
    int            refusals;

    function new();
      cmd_word    = CONTROL_WORD_RST;
      gap_len     = GAP_TICKS_RST;
      bit_len     = BIT_TICKS_RST;
      pulse_len   = PULSE_TICKS_RST;
      foreach (led_level[i]) led_level[i] = LVL_OFF;
      phase       = SER_IDLE;
      bit_pos     = '0;
      ticks_left  = '0;
      pulses_done = '0;
      data_pin    = 1'b0;
      clock_pin   = 1'b0;
      errors      = 0;
      words_seen  = 0;
      frames_sent = 0;
      sets_taken  = 0;
      refusals    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_CONTROL_WORD: cmd_word  = value;
        REG_GAP_TICKS:    gap_len   = value;
        REG_BIT_TICKS:    bit_len   = value[7:0];
        REG_PULSE_TICKS:  pulse_len = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function bit sending();
      return phase != SER_IDLE;
    endfunction

    // A tick count of zero behaves as one
    function logic [15:0] at_least_one(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function bit drive_level(logic [7:0] lvl);
      return lvl == LVL_OFF || lvl == LVL_MED || lvl == LVL_FULL;
    endfunction

    // Bit pos of the frame: command word, one word per LED, two zero words
    function logic frame_bit(int pos);
      int          slot;
      logic [15:0] wrd;
      slot = pos / 16;
      if (slot == 0) wrd = cmd_word;
      else if (slot <= LED_COUNT) wrd = {8'h00, led_level[slot - 1]};
      else wrd = 16'h0000;
      return wrd[15 - (pos % 16)];
    endfunction

    // Advance the serializer by one tick; high when the frame ends
    function bit step_serializer();
      if (phase == SER_IDLE) return 1'b0;
      if (ticks_left > 16'd1) begin
        ticks_left--;
        return 1'b0;
      end
      case (phase)
        SER_LEAD_GAP: begin
          bit_pos    = '0;
          data_pin   = frame_bit(0);
          phase      = SER_BITS;
          ticks_left = at_least_one({8'h00, bit_len});
        end
        SER_BITS: begin
          clock_pin = ~clock_pin;
          bit_pos++;
          if (bit_pos < FRAME_LEN) begin
            data_pin   = frame_bit(bit_pos);
            ticks_left = at_least_one({8'h00, bit_len});
          end else begin
            data_pin   = 1'b0;
            phase      = SER_LATCH_GAP;
            ticks_left = at_least_one(gap_len);
          end
        end
        SER_LATCH_GAP: begin
          pulses_done = '0;
          data_pin    = 1'b1;
          phase       = SER_PULSE_HIGH;
          ticks_left  = at_least_one({8'h00, pulse_len});
        end
        SER_PULSE_HIGH: begin
          data_pin   = 1'b0;
          phase      = SER_PULSE_LOW;
          ticks_left = at_least_one({8'h00, pulse_len});
        end
        SER_PULSE_LOW: begin
          pulses_done++;
          if (pulses_done < LATCH_COUNT) begin
            data_pin   = 1'b1;
            phase      = SER_PULSE_HIGH;
            ticks_left = at_least_one({8'h00, pulse_len});
          end else begin
            phase      = SER_TAIL_GAP;
            ticks_left = at_least_one(gap_len);
          end
        end
        default: begin
          clock_pin  = 1'b0;
          phase      = SER_IDLE;
          ticks_left = '0;
          frames_sent++;
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void begin_frame();
      phase      = SER_LEAD_GAP;
      ticks_left = at_least_one(gap_len);
      sets_taken++;
    endfunction

    // Predict the result of an accepted request word and queue it
    function void note_request(req_t w);
      rsp_t want;
      bit   busy;
      want = '0;
      busy = (phase != SER_IDLE);
      words_seen++;
      case (w.req_type)
        REQ_SET_ONE: begin
          if (w.led_index >= LED_COUNT) want.status = STAT_BAD_INDEX;
          else if (!drive_level(w.level)) want.status = STAT_BAD_LEVEL;
          else if (busy) want.status = STAT_BUSY;
          else begin
            led_level[w.led_index] = w.level;
            begin_frame();
          end
        end
        REQ_SET_ALL: begin
          if (!drive_level(w.level)) want.status = STAT_BAD_LEVEL;
          else if (busy) want.status = STAT_BUSY;
          else begin
            foreach (led_level[i]) led_level[i] = w.level;
            begin_frame();
          end
        end
        REQ_TICK: want.frame_done = step_serializer();
        REQ_READ: begin
          if (w.led_index >= LED_COUNT) want.status = STAT_BAD_INDEX;
          else want.read_level = led_level[w.led_index];
        end
        default: ;
      endcase
      if (want.status != STAT_OK) refusals++;
      want.data_line  = data_pin;
      want.clock_line = clock_pin;
      want.sending    = (phase != SER_IDLE);
      expected_words.push_back(want);
    endfunction

    function void compare_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", fname, want, got);
        errors++;
      end
    endfunction

    // Check a returned result word against the oldest prediction
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_words.size() == 0) begin
        $error("result word arrived with no request outstanding");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", {6'd0, want.status}, {6'd0, got.status});
      compare_field("read_level", want.read_level, got.read_level);
      compare_field("data_line", {7'd0, want.data_line}, {7'd0, got.data_line});
      compare_field("clock_line", {7'd0, want.clock_line}, {7'd0, got.clock_line});
      compare_field("sending", {7'd0, want.sending}, {7'd0, got.sending});
      compare_field("frame_done", {7'd0, want.frame_done}, {7'd0, got.frame_done});
    endfunction

    function void close_out();
      if (expected_words.size() != 0) begin
        $error("%0d result words never arrived", expected_words.size());
        errors++;
      end
    endfunction

  endclass

endpackage

`default_nettype wire

// ===== verif/led_bar_serial_frame_driver_tb.sv =====
// ---------------------------------------------------------------------------
// LED bar serial frame driver - testbench
// Drives request words with random gaps, stalls the result side at random
// and checks every result word against a scoreboard prediction. Covers the
// refusal order, reads while sending, whole frames under several register
// settings (zero counts included) and the opening of frames at the reset
// values and at the widest counts.
// ---------------------------------------------------------------------------
`default_nettype none

module led_bar_serial_frame_driver_tb;

  import lbsfd_pkg::*;
  import lbsfd_tb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int WORDS_PER_RUN = 160;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  req_t        in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_CONTROL_WORD;
  logic [15:0] cfg_data  = '0;

  bit          calm          = 1'b0;
  int          settings_used = 1;

  led_frame_scoreboard sb = new();

  led_bar_serial_frame_driver DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic req_t make_word(logic [1:0] kind, logic [3:0] idx, logic [7:0] lvl);
    req_t w;
    w.req_type  = kind;
    w.led_index = idx;
    w.level     = lvl;
    return w;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 2))
      0:       return LVL_OFF;
      1:       return LVL_MED;
      default: return LVL_FULL;
    endcase
  endfunction

  // Mostly ticks while a frame is out; when idle, sets (mostly well-formed) are the most common kind
  function automatic req_t pick_word();
    req_t w;
    int   roll;
    w.req_type  = 2'($urandom_range(0, 3));
    w.led_index = 4'($urandom_range(0, 15));
    w.level     = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (sb.sending() ? roll < 92 : roll < 35) begin
      w.req_type = REQ_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        w.req_type = REQ_SET_ONE;
        if ($urandom_range(0, 7) != 0) begin
          w.led_index = 4'($urandom_range(0, LED_COUNT - 1));
          w.level     = pick_level();
        end
      end else if (roll < 65) begin
        w.req_type = REQ_SET_ALL;
        if ($urandom_range(0, 7) != 0) w.level = pick_level();
      end else if (roll < 90) begin
        w.req_type = REQ_READ;
      end
    end
    return w;
  endfunction

  // Present one word after a random gap and hold it until taken
  task automatic send_word(input req_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(w);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Send a fixed number of ticks with random index and level bits
  task automatic send_ticks(input int count);
    req_t w;
    for (int k = 0; k < count; k++) begin
      w = make_word(REQ_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      send_word(w);
    end
  endtask

  // Tick until the predicted serializer is idle again
  task automatic drain_frame();
    req_t w;
    while (sb.sending()) begin
      w = make_word(REQ_TICK, 4'd0, 8'd0);
      w.led_index = 4'($urandom_range(0, 15));
      w.level     = 8'($urandom_range(0, 255));
      send_word(w);
    end
  endtask

  // Write all four registers back to back; caller holds the block idle
  task automatic apply_settings(input logic [15:0] cw, input logic [15:0] gap,
                                input logic [15:0] bitv, input logic [15:0] pulsev);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{REG_CONTROL_WORD, REG_GAP_TICKS, REG_BIT_TICKS, REG_PULSE_TICKS};
    vals = '{cw, gap, bitv, pulsev};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic random_run(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      // occasionally let the pipeline run dry
      if ($urandom_range(0, 79) == 0) settle();
      send_word(pick_word());
    end
    calm = 1'b0;
    drain_frame();
    settle();
  endtask

  task automatic run_directed();
    send_word(make_word(REQ_READ, 4'd0, LVL_OFF));
    // reads out of range return zero with bad index
    send_word(make_word(REQ_READ, 4'd15, 8'hff));
    send_word(make_word(REQ_READ, 4'd10, 8'h00));
    // tick with nothing to send changes nothing
    send_word(make_word(REQ_TICK, 4'd7, 8'h5a));
    // bad index wins over bad level
    send_word(make_word(REQ_SET_ONE, 4'd15, 8'h42));
    send_word(make_word(REQ_SET_ONE, 4'd9, 8'h80));
    send_word(make_word(REQ_SET_ALL, 4'd15, 8'h01));
    // set all ignores the index and starts a frame
    send_word(make_word(REQ_SET_ALL, 4'd14, LVL_MED));
    // refusals while the frame is out; bad index and bad level win over busy
    send_word(make_word(REQ_SET_ONE, 4'd3, LVL_FULL));
    send_word(make_word(REQ_SET_ONE, 4'd12, LVL_FULL));
    send_word(make_word(REQ_SET_ALL, 4'd0, 8'hf0));
    send_word(make_word(REQ_SET_ALL, 4'd0, LVL_OFF));
    // reads are served while sending
    send_word(make_word(REQ_READ, 4'd9, 8'h00));
    send_word(make_word(REQ_READ, 4'd11, 8'h00));
    send_word(make_word(REQ_TICK, 4'd0, 8'h00));
    // run through the lead gap and the first bits at reset timing
    calm = 1'b1;
    send_ticks(272);
    calm = 1'b0;
    send_word(make_word(REQ_READ, 4'd5, 8'hff));
    send_word(make_word(REQ_TICK, 4'd15, 8'hff));
    settle();
  endtask

  // Result side: random stall before each word
  initial begin : result_sink
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  // End the run if neither side moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $error("no word moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    apply_settings(16'($urandom_range(0, 65535)), 16'd1, 16'd1, 16'd1);
    random_run(WORDS_PER_RUN);
    // zero counts act as one; upper bits of the narrow registers are dropped
    apply_settings(16'hffff, 16'd0, 16'hab00, 16'hcd00);
    random_run(WORDS_PER_RUN);
    apply_settings(16'h0000, 16'd2, 16'd1, 16'd2);
    random_run(WORDS_PER_RUN);
    apply_settings(16'($urandom_range(0, 65535)), 16'd3, 16'd2, 16'd1);
    random_run(WORDS_PER_RUN);
    apply_settings(16'($urandom_range(0, 65535)), 16'd5, 16'd3, 16'd7);
    random_run(WORDS_PER_RUN);

    // start a frame with the widest counts and tick into its lead gap
    apply_settings(16'h8001, 16'hffff, 16'h00ff, 16'h00ff);
    calm = 1'b1;
    send_word(make_word(REQ_SET_ALL, 4'd2, LVL_FULL));
    send_word(make_word(REQ_SET_ONE, 4'd9, LVL_OFF));
    send_word(make_word(REQ_READ, 4'd4, 8'h00));
    send_ticks(40);
    calm = 1'b0;
    settle();
    repeat (8) @(negedge clk);

    sb.close_out();
    $display("Covered %0d request words under %0d register settings,", sb.words_seen,
             settings_used);
    $display("with %0d frames sent, %0d sets taken and %0d requests refused.",
             sb.frames_sent, sb.sets_taken, sb.refusals);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lbsfd_pkg.sv
rtl/lbsfd_front.sv
rtl/lbsfd_queue.sv
rtl/lbsfd_back.sv
rtl/led_bar_serial_frame_driver.sv
verif/lbsfd_tb_pkg.sv
verif/led_bar_serial_frame_driver_tb.sv
